/* hdl/chacha_pkg.sv */
`timescale 1ns / 1ps
// Shared types, constants and round functions for the ChaCha20 stream XOR unit.
// No dependencies; every other file in hdl/ imports this package.
package chacha_pkg;

  // Default number of double rounds per keystream block.
  localparam int DOUBLE_ROUNDS_DEF = 10;

  // Bytes per keystream block and the width of a byte position (64 means empty).
  localparam int BLOCK_BYTES = 64;
  localparam int POS_W       = 7;
  localparam int IDX_W       = 6;

  // Depth of the queue between the front and the back.
  localparam int QUEUE_DEPTH = 2;

  // Configuration port geometry and register indexes.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;

  localparam logic [CFG_IDX_W-1:0] REG_KEY_0      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_1      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_2      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_3      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_NONCE_LOW  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_NONCE_HIGH = 3'd5;

  // The constant words "expand 32-byte k".
  localparam logic [31:0] SIGMA_0 = 32'h6170_7865;
  localparam logic [31:0] SIGMA_1 = 32'h3320_646e;
  localparam logic [31:0] SIGMA_2 = 32'h7962_2d32;
  localparam logic [31:0] SIGMA_3 = 32'h6b20_6574;

  typedef logic [31:0] word_t;

  // One keystream block as eight little-endian 64-bit words.
  typedef logic [7:0][63:0] ks_block_t;

  // Beat payloads of the input and result channels.
  typedef struct packed {
    logic [7:0] data_in;
    logic       msg_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0] data_out;
    logic       last_out;
  } out_item_t;

  // Queue entry: the input beat plus where its keystream byte comes from.
  typedef struct packed {
    logic [7:0]       data_in;
    logic             msg_last;
    logic             new_blk;
    logic [IDX_W-1:0] byte_idx;
  } q_entry_t;

  // One configuration write as seen by the round core.
  typedef struct packed {
    logic                  valid;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
  } cfg_wr_t;

  // Requests from the back to the round core.
  typedef struct packed {
    logic take;   // the held block moves into the keystream buffer
    logic flush;  // the message ended, restart at counter zero
  } core_ctl_t;

  // Four words of one quarter round.
  typedef struct packed {
    word_t a;
    word_t b;
    word_t c;
    word_t d;
  } qr_t;

  function automatic word_t rotl32(input word_t v, input int unsigned n);
    return (v << n) | (v >> (32 - n));
  endfunction

  // Half of a quarter round: the first half rotates by 16 and 12,
  // the second half by 8 and 7.
  function automatic qr_t qr_half(input qr_t q, input logic second);
    qr_t   r;
    word_t x;
    word_t y;
    r.a = q.a + q.b;
    x   = q.d ^ r.a;
    r.d = second ? rotl32(x, 8) : rotl32(x, 16);
    r.c = q.c + r.d;
    y   = q.b ^ r.c;
    r.b = second ? rotl32(y, 7) : rotl32(y, 12);
    return r;
  endfunction

endpackage

/* hdl/chacha20_stream_xor_unit.sv */
`timescale 1ns / 1ps
// ChaCha20 stream XOR unit: one byte per beat, each XORed with the next keystream byte.
// Each accepted input beat passes through the queue to the registered result beat.
// Throughput: one byte per cycle within a message unless the output stalls or a block
// is not ready; the round core makes the next block while the current 64 bytes drain.
// The first byte of a message, and the first block after a configuration write, waits
// for that round core. Synchronous active-low reset clears the key, nonce and counter.
module chacha20_stream_xor_unit
  import chacha_pkg::*;
#(
  parameter int DOUBLE_ROUNDS = DOUBLE_ROUNDS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_item_t             out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic      q_push;
  q_entry_t  q_entry;
  logic      q_full;
  logic      q_pop;
  logic      q_valid;
  q_entry_t  q_head;
  logic      blk_valid;
  ks_block_t blk_data;
  core_ctl_t ctl;
  cfg_wr_t   cfg;

  // Configuration writes are always taken.
  assign cfg_ready = 1'b1;
  assign cfg.valid = cfg_valid;
  assign cfg.index = cfg_index;
  assign cfg.data  = cfg_data;

  chacha_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_push   (q_push),
    .q_entry  (q_entry),
    .q_full   (q_full)
  );

  chacha_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_entry),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_entry (q_head)
  );

  chacha_core #(
    .DOUBLE_ROUNDS (DOUBLE_ROUNDS)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .ctl       (ctl),
    .blk_valid (blk_valid),
    .blk_data  (blk_data)
  );

  chacha_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .blk_valid (blk_valid),
    .blk_data  (blk_data),
    .ctl       (ctl),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

/* hdl/chacha_fifo.sv */
`timescale 1ns / 1ps
// Short queue of classified beats between the front and the back.
// Depends on chacha_pkg for the entry type and the depth.
module chacha_fifo
  import chacha_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  q_entry_t push_entry,
  output logic     full,
  input  logic     pop,
  output logic     head_valid,
  output q_entry_t head_entry
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

  q_entry_t         mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] count_r;

  assign full       = (count_r == CNT_FULL);
  assign head_valid = (count_r != '0);
  assign head_entry = mem_r[rd_ptr_r];

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

/* hdl/chacha_front.sv */
`timescale 1ns / 1ps
// Input side: accepts beats and tags each with its keystream byte position.
// Depends on chacha_pkg for the payload and queue entry types.
module chacha_front
  import chacha_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_item_t in_data,
  output logic     q_push,
  output q_entry_t q_entry,
  input  logic     q_full
);

  localparam logic [POS_W-1:0] POS_EMPTY = POS_W'(BLOCK_BYTES);

  logic [POS_W-1:0] pos_r;
  logic [POS_W-1:0] pos_nxt;
  logic             new_blk;

  assign in_ready = !q_full;
  assign q_push   = in_valid && in_ready;

  // An empty buffer means this beat opens a fresh block at byte zero.
  assign new_blk          = (pos_r == POS_EMPTY);
  assign q_entry.data_in  = in_data.data_in;
  assign q_entry.msg_last = in_data.msg_last;
  assign q_entry.new_blk  = new_blk;
  assign q_entry.byte_idx = new_blk ? '0 : pos_r[IDX_W-1:0];

  // Next position; the last beat of a message, or the last byte of a block, empties the buffer.
  always_comb begin
    pos_nxt = pos_r;
    if (q_push) begin
      if (in_data.msg_last) begin
        pos_nxt = POS_EMPTY;
      end else if (new_blk) begin
        pos_nxt = POS_W'(1);
      end else begin
        pos_nxt = pos_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= POS_EMPTY;
    end else begin
      pos_r <= pos_nxt;
    end
  end

endmodule

/* hdl/chacha_core.sv */
`timescale 1ns / 1ps
// Configuration registers and the iterative ChaCha20 round core that makes
// the next keystream block ahead of use. Depends on chacha_pkg.
module chacha_core
  import chacha_pkg::*;
#(
  parameter int DOUBLE_ROUNDS = DOUBLE_ROUNDS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  cfg_wr_t   cfg,
  input  core_ctl_t ctl,
  output logic      blk_valid,
  output ks_block_t blk_data
);

  // Each double round is a column round and a diagonal round, each in two halves.
  localparam int STEPS  = 4 * DOUBLE_ROUNDS;
  localparam int STEP_W = $clog2(STEPS);
  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(STEPS - 1);

  typedef enum logic [3:0] {
    ST_INIT = 4'b0001,
    ST_RUN  = 4'b0010,
    ST_ADD  = 4'b0100,
    ST_HOLD = 4'b1000
  } core_state_t;

  core_state_t       state_r;
  logic [STEP_W-1:0] step_r;
  word_t             gen_ctr_r;
  logic [63:0]       key0_r;
  logic [63:0]       key1_r;
  logic [63:0]       key2_r;
  logic [63:0]       key3_r;
  logic [63:0]       nonce_lo_r;
  logic [31:0]       nonce_hi_r;
  word_t             w_r [16];
  ks_block_t         blk_r;

  word_t s [16];
  word_t w_step [16];

  assign blk_valid = (state_r == ST_HOLD);
  assign blk_data  = blk_r;

  // Input state of the block from constants, key, counter and nonce.
  always_comb begin
    s[0]  = SIGMA_0;
    s[1]  = SIGMA_1;
    s[2]  = SIGMA_2;
    s[3]  = SIGMA_3;
    s[4]  = key0_r[31:0];
    s[5]  = key0_r[63:32];
    s[6]  = key1_r[31:0];
    s[7]  = key1_r[63:32];
    s[8]  = key2_r[31:0];
    s[9]  = key2_r[63:32];
    s[10] = key3_r[31:0];
    s[11] = key3_r[63:32];
    s[12] = gen_ctr_r;
    s[13] = nonce_lo_r[31:0];
    s[14] = nonce_lo_r[63:32];
    s[15] = nonce_hi_r;
  end

  // One half round: four independent quarter-round halves, column or diagonal.
  always_comb begin
    int  ib;
    int  ic;
    int  id;
    qr_t q;
    for (int j = 0; j < 16; j++) begin
      w_step[j] = w_r[j];
    end
    for (int i = 0; i < 4; i++) begin
      ib = step_r[1] ? 4 + ((i + 1) % 4)  : 4 + i;
      ic = step_r[1] ? 8 + ((i + 2) % 4)  : 8 + i;
      id = step_r[1] ? 12 + ((i + 3) % 4) : 12 + i;
      q  = qr_half('{a: w_r[i], b: w_r[ib], c: w_r[ic], d: w_r[id]}, step_r[0]);
      w_step[i]  = q.a;
      w_step[ib] = q.b;
      w_step[ic] = q.c;
      w_step[id] = q.d;
    end
  end

  // Sequencer, block counter and configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_INIT;
      step_r     <= '0;
      gen_ctr_r  <= '0;
      key0_r     <= '0;
      key1_r     <= '0;
      key2_r     <= '0;
      key3_r     <= '0;
      nonce_lo_r <= '0;
      nonce_hi_r <= '0;
    end else begin
      if (cfg.valid) begin
        unique case (cfg.index)
          REG_KEY_0:      key0_r     <= cfg.data;
          REG_KEY_1:      key1_r     <= cfg.data;
          REG_KEY_2:      key2_r     <= cfg.data;
          REG_KEY_3:      key3_r     <= cfg.data;
          REG_NONCE_LOW:  nonce_lo_r <= cfg.data;
          REG_NONCE_HIGH: nonce_hi_r <= cfg.data[31:0];
          default: ;
        endcase
      end
      // A finished message restarts at counter zero; new settings remake
      // the pending block.
      if (ctl.flush) begin
        gen_ctr_r <= '0;
        state_r   <= ST_INIT;
      end else if (cfg.valid) begin
        state_r <= ST_INIT;
      end else begin
        unique case (state_r)
          ST_INIT: begin
            step_r  <= '0;
            state_r <= ST_RUN;
          end
          ST_RUN: begin
            step_r <= step_r + 1'b1;
            if (step_r == STEP_LAST) begin
              state_r <= ST_ADD;
            end
          end
          ST_ADD: begin
            state_r <= ST_HOLD;
          end
          ST_HOLD: begin
            if (ctl.take) begin
              gen_ctr_r <= gen_ctr_r + 1'b1;
              state_r   <= ST_INIT;
            end
          end
          default: state_r <= ST_INIT;
        endcase
      end
    end
  end

  // Working state and the finished block with the feed-forward add.
  always_ff @(posedge clk) begin
    if (state_r == ST_INIT) begin
      for (int j = 0; j < 16; j++) begin
        w_r[j] <= s[j];
      end
    end else if (state_r == ST_RUN) begin
      for (int j = 0; j < 16; j++) begin
        w_r[j] <= w_step[j];
      end
    end
    if (state_r == ST_ADD) begin
      for (int k = 0; k < 8; k++) begin
        blk_r[k] <= {w_r[2*k+1] + s[2*k+1], w_r[2*k] + s[2*k]};
      end
    end
  end

endmodule

/* hdl/chacha_back.sv */
`timescale 1ns / 1ps
// Output side: XORs queued beats with the keystream and holds the result beat.
// Depends on chacha_pkg for the entry, block and payload types.
module chacha_back
  import chacha_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      q_valid,
  input  q_entry_t  q_head,
  output logic      q_pop,
  input  logic      blk_valid,
  input  ks_block_t blk_data,
  output core_ctl_t ctl,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  ks_block_t   buf_r;
  logic        out_valid_r;
  out_item_t   out_data_r;
  logic [63:0] ks_word;
  logic [7:0]  ks_byte;
  logic        out_free;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // A beat that opens a block waits for the round core.
  assign out_free  = !out_valid_r || out_ready;
  assign q_pop     = q_valid && (!q_head.new_blk || blk_valid) && out_free;
  assign ctl.take  = q_pop && q_head.new_blk;
  assign ctl.flush = q_pop && q_head.msg_last;

  // Keystream byte: byte zero of the fresh block, or from the buffer.
  assign ks_word = buf_r[q_head.byte_idx[5:3]];
  assign ks_byte = q_head.new_blk ? blk_data[0][7:0]
                                  : ks_word[{q_head.byte_idx[2:0], 3'b000} +: 8];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (q_pop) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Result beat and keystream buffer.
  always_ff @(posedge clk) begin
    if (q_pop) begin
      out_data_r.data_out <= q_head.data_in ^ ks_byte;
      out_data_r.last_out <= q_head.msg_last;
    end
    if (ctl.take) begin
      buf_r <= blk_data;
    end
  end

endmodule
